// File: hdl/ip_address_classifier_core_assert.svh
// assertion macros for the ip address classifier
`ifndef IP_ADDRESS_CLASSIFIER_CORE_ASSERT_SVH
`define IP_ADDRESS_CLASSIFIER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define IPAC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ipac assertion failed");
`define IPAC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("ipac forbidden condition seen");
`else
`define IPAC_ASSERT(lbl, clk, rst_n, prop)
`define IPAC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// File: hdl/ipac_pkg.sv
// types and category codes shared by the ip address classifier
`default_nettype none

package ipac_pkg;

	typedef logic [4:0] category_t;

	typedef struct packed {
		logic        command;
		logic [63:0] address_high;
		logic [63:0] address_low;
		logic [7:0]  prefix_length;
	} in_word_t;

	localparam logic FAMILY_V4 = 1'b0;
	localparam logic FAMILY_V6 = 1'b1;

	localparam logic [7:0] V4_MAX_PREFIX = 8'd32;

	localparam category_t CAT_BAD_PREFIX   = 5'd0;
	localparam category_t CAT_ANY          = 5'd1;
	localparam category_t CAT_ZERO_NET     = 5'd2;
	localparam category_t CAT_CLASS_A      = 5'd3;
	localparam category_t CAT_LOOPBACK     = 5'd4;
	localparam category_t CAT_CLASS_B      = 5'd5;
	localparam category_t CAT_CLASS_C      = 5'd6;
	localparam category_t CAT_CLASS_D      = 5'd7;
	localparam category_t CAT_CLASS_E      = 5'd8;
	localparam category_t CAT_LIMITED_BC   = 5'd9;
	localparam category_t CAT_NET_ID       = 5'd10;
	localparam category_t CAT_DIRECTED_BC  = 5'd11;
	localparam category_t CAT_V6_UNSPEC    = 5'd12;
	localparam category_t CAT_V6_LOOPBACK  = 5'd13;
	localparam category_t CAT_V6_COMPAT    = 5'd14;
	localparam category_t CAT_V6_MAPPED    = 5'd15;
	localparam category_t CAT_V6_LINKLOCAL = 5'd16;
	localparam category_t CAT_V6_SITELOCAL = 5'd17;
	localparam category_t CAT_V6_MULTICAST = 5'd18;
	localparam category_t CAT_V6_UNICAST   = 5'd19;

endpackage

`default_nettype wire

// File: hdl/ipac_classify.sv
// combinational address classification for one input word
`default_nettype none

module ipac_classify (
	input  var ipac_pkg::in_word_t  word,
	output var ipac_pkg::category_t category
);

	logic [31:0]         a;
	logic [7:0]          pfx;
	logic [31:0]         hmask;
	logic [31:0]         hbits;
	logic                host_chk;
	logic                net_id;
	logic                bcast;
	logic                is_abc;
	ipac_pkg::category_t cls_cat;
	ipac_pkg::category_t v4_cat;
	ipac_pkg::category_t v6_cat;
	logic [63:0]         hi;
	logic [63:0]         lo;
	logic                hi_zero;

	assign a   = word.address_low[31:0];
	assign pfx = word.prefix_length;
	assign hi  = word.address_high;
	assign lo  = word.address_low;

	// host part of the address under the prefix mask
	assign hmask    = (pfx[7:5] != 3'd0) ? 32'd0 : (32'hFFFF_FFFF >> pfx[4:0]);
	assign hbits    = a & hmask;
	assign host_chk = (pfx != 8'd0);
	assign net_id   = (hbits == 32'd0);
	assign bcast    = (hbits == hmask);

	always_comb begin
		is_abc  = 1'b0;
		cls_cat = ipac_pkg::CAT_CLASS_E;
		if (!a[31]) begin
			if (a == 32'd0) begin
				cls_cat = ipac_pkg::CAT_ANY;
			end else if (a[31:24] == 8'h00) begin
				cls_cat = ipac_pkg::CAT_ZERO_NET;
			end else if (a[31:24] == 8'h7F) begin
				cls_cat = ipac_pkg::CAT_LOOPBACK;
			end else begin
				cls_cat = ipac_pkg::CAT_CLASS_A;
				is_abc  = 1'b1;
			end
		end else if (a[30] == 1'b0) begin
			cls_cat = ipac_pkg::CAT_CLASS_B;
			is_abc  = 1'b1;
		end else if (a[29] == 1'b0) begin
			cls_cat = ipac_pkg::CAT_CLASS_C;
			is_abc  = 1'b1;
		end else if (a[28] == 1'b0) begin
			cls_cat = ipac_pkg::CAT_CLASS_D;
		end else if (a == 32'hFFFF_FFFF) begin
			cls_cat = ipac_pkg::CAT_LIMITED_BC;
		end
	end

	always_comb begin
		if (pfx > ipac_pkg::V4_MAX_PREFIX) begin
			v4_cat = ipac_pkg::CAT_BAD_PREFIX;
		end else if (is_abc && host_chk && net_id) begin
			v4_cat = ipac_pkg::CAT_NET_ID;
		end else if (is_abc && host_chk && bcast) begin
			v4_cat = ipac_pkg::CAT_DIRECTED_BC;
		end else begin
			v4_cat = cls_cat;
		end
	end

	assign hi_zero = (hi == 64'd0);

	always_comb begin
		if (hi_zero && lo == 64'd0) begin
			v6_cat = ipac_pkg::CAT_V6_UNSPEC;
		end else if (hi_zero && lo == 64'd1) begin
			v6_cat = ipac_pkg::CAT_V6_LOOPBACK;
		end else if (hi_zero && lo[63:32] == 32'd0 && lo[31:1] != 31'd0) begin
			v6_cat = ipac_pkg::CAT_V6_COMPAT;
		end else if (hi_zero && lo[63:32] == 32'h0000_FFFF) begin
			v6_cat = ipac_pkg::CAT_V6_MAPPED;
		end else if (hi[63:54] == 10'h3FA) begin
			v6_cat = ipac_pkg::CAT_V6_LINKLOCAL;
		end else if (hi[63:54] == 10'h3FB) begin
			v6_cat = ipac_pkg::CAT_V6_SITELOCAL;
		end else if (hi[63:56] == 8'hFF) begin
			v6_cat = ipac_pkg::CAT_V6_MULTICAST;
		end else begin
			v6_cat = ipac_pkg::CAT_V6_UNICAST;
		end
	end

	assign category = (word.command == ipac_pkg::FAMILY_V6) ? v6_cat : v4_cat;

endmodule

`default_nettype wire

// File: hdl/ip_address_classifier_core.sv
// The classifier takes one IPv4 or IPv6 address word per clock while item_stall is
// low and returns one category code for each. An accepted word is held in the input
// register, is classified by shallow compare and mask logic, and moves into the result
// register, from which it is offered; the sustained rate is one word per cycle while
// result_stall stays low. The input register keeps accepting while a finished
// result waits under result_stall; item_stall rises only when both registers hold
// words and the result is stalled. The block keeps no state across words.
`default_nettype none
`include "ip_address_classifier_core_assert.svh"

module ip_address_classifier_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         item_valid,
	output logic        item_stall,
	input  wire         command,
	input  wire  [63:0] address_high,
	input  wire  [63:0] address_low,
	input  wire  [7:0]  prefix_length,
	output logic        result_valid,
	input  wire         result_stall,
	output logic [4:0]  category
);

	ipac_pkg::in_word_t  word_s1;
	logic                valid_s1;
	ipac_pkg::category_t cat_comb;
	ipac_pkg::category_t cat_s2;
	logic                valid_s2;
	logic                adv_s2;
	logic                load_s1;
	logic                move_s1;
	logic                bad_pfx_s1;
	logic                is_v6_s1;

	assign adv_s2     = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !adv_s2;
	assign load_s1    = item_valid && !item_stall;
	assign move_s1    = valid_s1 && adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			word_s1.command       <= command;
			word_s1.address_high  <= address_high;
			word_s1.address_low   <= address_low;
			word_s1.prefix_length <= prefix_length;
		end
	end

	ipac_classify u_classify (
		.word     (word_s1),
		.category (cat_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			cat_s2 <= cat_comb;
		end
	end

	assign result_valid = valid_s2;
	assign category     = cat_s2;

	assign bad_pfx_s1 = (word_s1.command == ipac_pkg::FAMILY_V4) &&
		(word_s1.prefix_length > ipac_pkg::V4_MAX_PREFIX);
	assign is_v6_s1   = (word_s1.command == ipac_pkg::FAMILY_V6);

	`IPAC_ASSERT(a_load_fills_s1, clk, arst_n, load_s1 |=> valid_s1)
	`IPAC_ASSERT(a_stall_only_full, clk, arst_n, item_stall |-> (valid_s1 && valid_s2 && result_stall))
	`IPAC_ASSERT(a_bad_prefix, clk, arst_n, (move_s1 && bad_pfx_s1) |=> category == ipac_pkg::CAT_BAD_PREFIX)
	`IPAC_ASSERT(a_v6_range, clk, arst_n, (move_s1 && is_v6_s1) |=> category >= ipac_pkg::CAT_V6_UNSPEC)
	`IPAC_ASSERT_NEVER(a_code_range, clk, arst_n, result_valid && category > ipac_pkg::CAT_V6_UNICAST)

endmodule

`default_nettype wire

// File: verif/tb.sv
// testbench for the ip address classifier: directed table, random words, predicted categories
module tb;

	localparam int RANDOM_WORDS = 1600;
	localparam int QUIET_FROM = 400;
	localparam int QUIET_TO = 700;
	localparam int HOLD_AT = 500;
	localparam int HOLD_CYCLES = 40;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT = 100000;

	typedef struct packed {
		logic                family;
		logic [63:0]         high;
		logic [63:0]         low;
		logic [7:0]          prefix;
		logic                typed;
		ipac_pkg::category_t category;
	} directed_row_t;

	localparam int DIRECTED_COUNT = 26;
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{ipac_pkg::FAMILY_V4, 64'h0, 64'h0, 8'd0, 1'b1, ipac_pkg::CAT_ANY},
		'{ipac_pkg::FAMILY_V4, 64'h0, 64'h1, 8'd0, 1'b1, ipac_pkg::CAT_ZERO_NET},
		'{ipac_pkg::FAMILY_V4, 64'h0, 64'h7f000001, 8'd8, 1'b1, ipac_pkg::CAT_LOOPBACK},
		'{ipac_pkg::FAMILY_V4, 64'h0, 64'h7fffffff, 8'd32, 1'b1, ipac_pkg::CAT_LOOPBACK},
		'{ipac_pkg::FAMILY_V4, 64'h0, 64'h0a000000, 8'd8, 1'b1, ipac_pkg::CAT_NET_ID},
		'{ipac_pkg::FAMILY_V4, 64'h0, 64'h0affffff, 8'd8, 1'b1, ipac_pkg::CAT_DIRECTED_BC},
		'{ipac_pkg::FAMILY_V4, 64'h0, 64'h0a010203, 8'd0, 1'b1, ipac_pkg::CAT_CLASS_A},
		'{ipac_pkg::FAMILY_V4, 64'h0, 64'h0a010203, 8'd32, 1'b1, ipac_pkg::CAT_NET_ID},
		'{ipac_pkg::FAMILY_V4, 64'h0, 64'h80000000, 8'd1, 1'b1, ipac_pkg::CAT_NET_ID},
		'{ipac_pkg::FAMILY_V4, 64'h0, 64'hac10ffff, 8'd16, 1'b1, ipac_pkg::CAT_DIRECTED_BC},
		'{ipac_pkg::FAMILY_V4, 64'h0, 64'hc0a80105, 8'd24, 1'b1, ipac_pkg::CAT_CLASS_C},
		'{ipac_pkg::FAMILY_V4, 64'h0, 64'he0000001, 8'd4, 1'b1, ipac_pkg::CAT_CLASS_D},
		'{ipac_pkg::FAMILY_V4, 64'h0, 64'hf0000000, 8'd0, 1'b1, ipac_pkg::CAT_CLASS_E},
		'{ipac_pkg::FAMILY_V4, 64'h0, 64'hffffffff, 8'd32, 1'b1, ipac_pkg::CAT_LIMITED_BC},
		'{ipac_pkg::FAMILY_V4, 64'h0, 64'h0a010203, 8'd33, 1'b1, ipac_pkg::CAT_BAD_PREFIX},
		'{ipac_pkg::FAMILY_V4, {64{1'b1}}, 64'hffffffff_0a010203, 8'd255, 1'b1,
			ipac_pkg::CAT_BAD_PREFIX},
		'{ipac_pkg::FAMILY_V4, {64{1'b1}}, 64'hffffffff_c0000001, 8'd31, 1'b0,
			ipac_pkg::CAT_BAD_PREFIX},
		'{ipac_pkg::FAMILY_V6, 64'h0, 64'h0, 8'd255, 1'b1, ipac_pkg::CAT_V6_UNSPEC},
		'{ipac_pkg::FAMILY_V6, 64'h0, 64'h1, 8'd128, 1'b1, ipac_pkg::CAT_V6_LOOPBACK},
		'{ipac_pkg::FAMILY_V6, 64'h0, 64'h2, 8'd0, 1'b1, ipac_pkg::CAT_V6_COMPAT},
		'{ipac_pkg::FAMILY_V6, 64'h0, 64'h0000ffff_c0a80001, 8'd0, 1'b0,
			ipac_pkg::CAT_BAD_PREFIX},
		'{ipac_pkg::FAMILY_V6, 64'hfe80000000000000, 64'h1, 8'd64, 1'b1,
			ipac_pkg::CAT_V6_LINKLOCAL},
		'{ipac_pkg::FAMILY_V6, 64'hfec0000000000000, 64'h0, 8'd0, 1'b1,
			ipac_pkg::CAT_V6_SITELOCAL},
		'{ipac_pkg::FAMILY_V6, 64'hff02000000000000, 64'h1, 8'd0, 1'b1,
			ipac_pkg::CAT_V6_MULTICAST},
		'{ipac_pkg::FAMILY_V6, 64'h0, 64'h00000001_00000000, 8'd0, 1'b0,
			ipac_pkg::CAT_BAD_PREFIX},
		'{ipac_pkg::FAMILY_V6, 64'h20010db8_00000000, 64'h0, 8'd0, 1'b1,
			ipac_pkg::CAT_V6_UNICAST}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        command = ipac_pkg::FAMILY_V4;
	logic [63:0] address_high = '0;
	logic [63:0] address_low = '0;
	logic [7:0]  prefix_length = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [4:0]  category;

	ipac_pkg::category_t pending_categories [$];
	int                  words_sent = 0;
	int                  mismatches = 0;
	int                  cycle_count = 0;
	bit                  hold_done = 1'b0;

	ip_address_classifier_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.command       (command),
		.address_high  (address_high),
		.address_low   (address_low),
		.prefix_length (prefix_length),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.category      (category)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit in_quiet_stretch();
		return words_sent >= QUIET_FROM && words_sent < QUIET_TO;
	endfunction

	function automatic ipac_pkg::category_t predict_category(input ipac_pkg::in_word_t w);
		logic [31:0]         a;
		logic [31:0]         host_mask;
		logic [63:0]         hi;
		logic [63:0]         lo;
		ipac_pkg::category_t cls;
		a = w.address_low[31:0];
		hi = w.address_high;
		lo = w.address_low;
		if (w.command == ipac_pkg::FAMILY_V6) begin
			if (hi == '0 && lo == '0)
				return ipac_pkg::CAT_V6_UNSPEC;
			if (hi == '0 && lo == 64'h1)
				return ipac_pkg::CAT_V6_LOOPBACK;
			if (hi == '0 && lo[63:32] == '0)
				return ipac_pkg::CAT_V6_COMPAT;
			if (hi == '0 && lo[63:32] == 32'h0000ffff)
				return ipac_pkg::CAT_V6_MAPPED;
			if (hi[63:54] == 10'h3fa)
				return ipac_pkg::CAT_V6_LINKLOCAL;
			if (hi[63:54] == 10'h3fb)
				return ipac_pkg::CAT_V6_SITELOCAL;
			if (hi[63:56] == 8'hff)
				return ipac_pkg::CAT_V6_MULTICAST;
			return ipac_pkg::CAT_V6_UNICAST;
		end
		if (w.prefix_length > ipac_pkg::V4_MAX_PREFIX)
			return ipac_pkg::CAT_BAD_PREFIX;
		if (a == '0)
			return ipac_pkg::CAT_ANY;
		if (a[31:24] == 8'h00)
			return ipac_pkg::CAT_ZERO_NET;
		if (a[31:24] == 8'h7f)
			return ipac_pkg::CAT_LOOPBACK;
		if (a[31] == 1'b0)
			cls = ipac_pkg::CAT_CLASS_A;
		else if (a[31:30] == 2'b10)
			cls = ipac_pkg::CAT_CLASS_B;
		else if (a[31:29] == 3'b110)
			cls = ipac_pkg::CAT_CLASS_C;
		else if (a[31:28] == 4'b1110)
			return ipac_pkg::CAT_CLASS_D;
		else if (a == 32'hffffffff)
			return ipac_pkg::CAT_LIMITED_BC;
		else
			return ipac_pkg::CAT_CLASS_E;
		if (w.prefix_length == 8'd0)
			return cls;
		host_mask = (w.prefix_length >= ipac_pkg::V4_MAX_PREFIX) ? 32'h0 :
			(32'hffffffff >> w.prefix_length);
		if ((a & host_mask) == '0)
			return ipac_pkg::CAT_NET_ID;
		if ((a & host_mask) == host_mask)
			return ipac_pkg::CAT_DIRECTED_BC;
		return cls;
	endfunction

	function automatic ipac_pkg::in_word_t random_word();
		ipac_pkg::in_word_t w;
		logic [31:0]        r;
		logic [31:0]        host_mask;
		r = $urandom;
		w.command = ($urandom_range(99) < 40) ? ipac_pkg::FAMILY_V6 : ipac_pkg::FAMILY_V4;
		w.address_high = {$urandom, $urandom};
		w.address_low = {$urandom, $urandom};
		w.prefix_length = r[7:0];
		if (w.command == ipac_pkg::FAMILY_V4) begin
			case ($urandom_range(9))
				0: w.address_low[31:0] = '0;
				1: w.address_low[31:24] = 8'h00;
				2: w.address_low[31:24] = 8'h7f;
				3: w.address_low[31:0] = 32'hffffffff;
				default: ;
			endcase
			case ($urandom_range(9))
				0: ;
				1: w.prefix_length = 8'd0;
				default: w.prefix_length = 8'($urandom_range(32, 1));
			endcase
			if (w.prefix_length != 8'd0 && w.prefix_length <= ipac_pkg::V4_MAX_PREFIX) begin
				host_mask = (w.prefix_length == ipac_pkg::V4_MAX_PREFIX) ? 32'h0 :
					(32'hffffffff >> w.prefix_length);
				case ($urandom_range(2))
					0: w.address_low[31:0] = w.address_low[31:0] & ~host_mask;
					1: w.address_low[31:0] = w.address_low[31:0] | host_mask;
					default: ;
				endcase
			end
		end else begin
			case ($urandom_range(7))
				0: begin
					w.address_high = '0;
					w.address_low = 64'($urandom_range(3));
				end
				1: begin
					w.address_high = '0;
					w.address_low[63:32] = '0;
				end
				2: begin
					w.address_high = '0;
					w.address_low[63:32] = 32'h0000ffff;
				end
				3: w.address_high[63:54] = 10'h3fa;
				4: w.address_high[63:54] = 10'h3fb;
				5: w.address_high[63:56] = 8'hff;
				6: w.address_high = '0;
				default: ;
			endcase
		end
		return w;
	endfunction

	task automatic offer_word(input ipac_pkg::in_word_t w, input ipac_pkg::category_t expected);
		logic [31:0] r;
		while (!in_quiet_stretch() && $urandom_range(99) < 37) begin
			r = $urandom;
			item_valid <= 1'b0;
			command <= r[0];
			address_high <= {$urandom, $urandom};
			address_low <= {$urandom, $urandom};
			prefix_length <= r[15:8];
			@(posedge clk);
		end
		item_valid <= 1'b1;
		command <= w.command;
		address_high <= w.address_high;
		address_low <= w.address_low;
		prefix_length <= w.prefix_length;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		pending_categories.push_back(expected);
		words_sent++;
	endtask

	initial begin
		ipac_pkg::in_word_t w;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED_ROWS[i]) begin
			w.command = DIRECTED_ROWS[i].family;
			w.address_high = DIRECTED_ROWS[i].high;
			w.address_low = DIRECTED_ROWS[i].low;
			w.prefix_length = DIRECTED_ROWS[i].prefix;
			offer_word(w, DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].category :
				predict_category(w));
		end
		repeat (RANDOM_WORDS) begin
			w = random_word();
			offer_word(w, predict_category(w));
		end
		item_valid <= 1'b0;
		while (pending_categories.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// result side: random stalls, one long hold-off inside the quiet stretch
	initial begin
		forever begin
			@(posedge clk);
			if (!hold_done && words_sent >= HOLD_AT) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				result_stall <= 1'b0;
			end else begin
				result_stall <= !in_quiet_stretch() && $urandom_range(99) < 37;
			end
		end
	end

	always @(posedge clk) begin
		ipac_pkg::category_t expected;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_categories.size() == 0) begin
				$display("%0t: unexpected word, got category %0d", $time, category);
				mismatches++;
			end else begin
				expected = pending_categories.pop_front();
				if (category !== expected) begin
					$display("%0t: category mismatch, expected %0d, got %0d",
						$time, expected, category);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/ipac_pkg.sv
hdl/ipac_classify.sv
hdl/ip_address_classifier_core.sv
verif/tb.sv
